// ----- design/lkc_pkg.sv -----
// Shared constants and types of the LRU keyed cache.
// No dependencies; every other design file imports this package.
package lkc_pkg;

   localparam int LKC_ENTRIES      = 16;
   localparam int LKC_PAYLOAD_BITS = 64;
   localparam int KEY_BITS         = 64;
   localparam int WORD_BITS        = 64;
   localparam int FUNC_BITS        = 2;
   localparam int STATUS_BITS      = 3;
   localparam int CAP_BITS         = 5;
   localparam int CAP_RESET        = 16;
   // Position and count width that covers every legal ENTRIES (up to 256).
   localparam int IDX_BITS         = 9;

   localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_FILL   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_INVAL  = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_HIT     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_MISS    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FILLED  = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_INVAL   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_NOENTRY = 3'd4;

   // Command broadcast to every cell of the recency chain.
   typedef struct packed {
      logic                load;      // cell 0 takes the broadcast entry
      logic                shift_dn;  // cells 1..limit take their left neighbor
      logic                shift_up;  // cells pos..last take their right neighbor
      logic [IDX_BITS-1:0] limit;
      logic [IDX_BITS-1:0] pos;
   } cell_ctl_type;

endpackage

// ----- design/lkc_channels.sv -----
// Handshake channels of the LRU keyed cache: request, response, capacity write.
// Depends on lkc_pkg for field widths.
interface lkc_req_if import lkc_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [FUNC_BITS-1:0] func;
   logic [KEY_BITS-1:0]  lookup_key;
   logic [WORD_BITS-1:0] fill_value;

   modport source (output valid, func, lookup_key, fill_value, input ready);
   modport sink   (input valid, func, lookup_key, fill_value, output ready);
endinterface

interface lkc_rsp_if import lkc_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [WORD_BITS-1:0]   read_value;
   logic                   evicted_flag;
   logic [KEY_BITS-1:0]    evicted_key;

   modport source (output valid, status, read_value, evicted_flag, evicted_key, input ready);
   modport sink   (input valid, status, read_value, evicted_flag, evicted_key, output ready);
endinterface

interface lkc_csr_if import lkc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CAP_BITS-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

// ----- design/lkc_cell.sv -----
// One slot of the recency chain: valid bit, key and payload, plus key compare.
// Position in the chain is the recency rank. Depends on lkc_pkg.
module lkc_cell import lkc_pkg::*; #(
   parameter int IDX          = 0,
   parameter int PAYLOAD_BITS = LKC_PAYLOAD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cell_ctl_type            ctl,
   input  logic [KEY_BITS-1:0]     load_key,
   input  logic [PAYLOAD_BITS-1:0] load_pay,
   input  logic [KEY_BITS-1:0]     cmp_key,
   input  logic                    left_valid,
   input  logic [KEY_BITS-1:0]     left_key,
   input  logic [PAYLOAD_BITS-1:0] left_pay,
   input  logic                    right_valid,
   input  logic [KEY_BITS-1:0]     right_key,
   input  logic [PAYLOAD_BITS-1:0] right_pay,
   output logic                    valid_o,
   output logic [KEY_BITS-1:0]     key_o,
   output logic [PAYLOAD_BITS-1:0] pay_o,
   output logic                    hit_o
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(IDX);

   logic                    valid_ff, valid_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      pay_in   = pay_ff;
      if (ctl.load && MY_IDX == '0) begin
         valid_in = 1'b1;
         key_in   = load_key;
         pay_in   = load_pay;
      end else if (ctl.shift_dn && MY_IDX != '0 && MY_IDX <= ctl.limit) begin
         valid_in = left_valid;
         key_in   = left_key;
         pay_in   = left_pay;
      end else if (ctl.shift_up && MY_IDX >= ctl.pos) begin
         valid_in = right_valid;
         key_in   = right_key;
         pay_in   = right_pay;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
      pay_ff <= pay_in;
   end

   assign valid_o = valid_ff;
   assign key_o   = key_ff;
   assign pay_o   = pay_ff;
   assign hit_o   = valid_ff && (key_ff == cmp_key);

endmodule

// ----- design/lru_keyed_cache.sv -----
// Top level of the LRU keyed cache: request/response control over a chain of cells.
// Depends on lkc_pkg, lkc_channels and lkc_cell.
//
//   channel | dir | handshake      | carries
//   --------+-----+----------------+------------------------------------------
//   req_ch  | in  | valid / ready  | func, lookup_key, fill_value
//   rsp_ch  | out | valid / ready  | status, read_value, evicted_flag, evicted_key
//   csr_ch  | in  | valid / ready  | capacity (always ready)
//
// Per request, the accept edge registers the request; then all cells compare the
// key at once and the chain shifts by one slot (recency order = chain position),
// writing the response register. That step waits while a previous response is
// still held by rsp_ch, and no new request is taken until it is done.
// Reset clears all valid bits and sets capacity to 16.
module lru_keyed_cache import lkc_pkg::*; #(
   parameter int ENTRIES      = LKC_ENTRIES,
   parameter int PAYLOAD_BITS = LKC_PAYLOAD_BITS
) (
   input  logic     clock,
   input  logic     reset,
   lkc_req_if.sink  req_ch,
   lkc_rsp_if.source rsp_ch,
   lkc_csr_if.sink  csr_ch
);

   localparam int OCC_W = $clog2(ENTRIES + 1);

   logic                    busy_ff, busy_in;
   logic [FUNC_BITS-1:0]    func_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [PAYLOAD_BITS-1:0] val_ff;
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [CAP_BITS-1:0]     cap_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [WORD_BITS-1:0]    read_ff, read_in;
   logic                    evf_ff, evf_in;
   logic [KEY_BITS-1:0]     evk_ff, evk_in;

   logic                    cell_valid [ENTRIES];
   logic [KEY_BITS-1:0]     cell_key   [ENTRIES];
   logic [PAYLOAD_BITS-1:0] cell_pay   [ENTRIES];
   logic [ENTRIES-1:0]      hit;

   logic                    accept;
   logic                    fire;
   logic                    hit_any;
   logic [IDX_BITS-1:0]     hit_pos;
   logic [PAYLOAD_BITS-1:0] hit_pay;
   logic [KEY_BITS-1:0]     lru_key;
   logic [OCC_W-1:0]        cap_eff;
   logic                    evict;
   cell_ctl_type            cmd, cell_ctl;
   logic [PAYLOAD_BITS-1:0] load_pay;

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = !busy_ff;
   assign csr_ch.ready  = 1'b1;
   assign fire          = busy_ff && (!rsp_valid_ff || rsp_ch.ready);

   // Chain of cells, position 0 is the most recent.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic                    lv, rv;
      logic [KEY_BITS-1:0]     lk, rk;
      logic [PAYLOAD_BITS-1:0] lp, rp;

      if (g == 0) begin : g_first
         assign lv = 1'b0;
         assign lk = '0;
         assign lp = '0;
      end else begin : g_mid
         assign lv = cell_valid[g-1];
         assign lk = cell_key[g-1];
         assign lp = cell_pay[g-1];
      end

      if (g == ENTRIES - 1) begin : g_last
         assign rv = 1'b0;
         assign rk = '0;
         assign rp = '0;
      end else begin : g_inner
         assign rv = cell_valid[g+1];
         assign rk = cell_key[g+1];
         assign rp = cell_pay[g+1];
      end

      lkc_cell #(
         .IDX          (g),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .load_key    (key_ff),
         .load_pay    (load_pay),
         .cmp_key     (key_ff),
         .left_valid  (lv),
         .left_key    (lk),
         .left_pay    (lp),
         .right_valid (rv),
         .right_key   (rk),
         .right_pay   (rp),
         .valid_o     (cell_valid[g]),
         .key_o       (cell_key[g]),
         .pay_o       (cell_pay[g]),
         .hit_o       (hit[g])
      );
   end

   // Keys are unique among valid cells, so hit is at most one-hot.
   always_comb begin
      hit_pos = '0;
      hit_pay = '0;
      lru_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_pos = hit_pos | (hit[i] ? IDX_BITS'(i) : '0);
         hit_pay = hit_pay | (hit[i] ? cell_pay[i] : '0);
         // least recent valid entry sits at position occupancy-1
         lru_key = lru_key
                 | ((cell_valid[i] && IDX_BITS'(i) + 1'b1 == IDX_BITS'(occ_ff))
                    ? cell_key[i] : '0);
      end
   end

   assign hit_any = |hit;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = OCC_W'(1);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = OCC_W'(ENTRIES);
      end else begin
         cap_eff = OCC_W'(cap_ff);
      end
   end

   assign evict = (occ_ff >= cap_eff);

   always_comb begin
      cmd       = '0;
      load_pay  = val_ff;
      occ_in    = occ_ff;
      status_in = ST_MISS;
      read_in   = '0;
      evf_in    = 1'b0;
      evk_in    = '0;
      case (func_ff)
         FUNC_LOOKUP: begin
            if (hit_any) begin
               cmd.load     = 1'b1;
               cmd.shift_dn = 1'b1;
               cmd.limit    = hit_pos;
               load_pay     = hit_pay;
               status_in    = ST_HIT;
               read_in      = WORD_BITS'(hit_pay);
            end
         end
         FUNC_FILL: begin
            status_in    = ST_FILLED;
            cmd.load     = 1'b1;
            cmd.shift_dn = 1'b1;
            if (hit_any) begin
               cmd.limit = hit_pos;
            end else if (evict) begin
               // oldest entry falls off the end of the valid run
               cmd.limit = IDX_BITS'(occ_ff - 1'b1);
               evf_in    = 1'b1;
               evk_in    = lru_key;
            end else begin
               cmd.limit = IDX_BITS'(occ_ff);
               occ_in    = occ_ff + 1'b1;
            end
         end
         FUNC_INVAL: begin
            if (hit_any) begin
               cmd.shift_up = 1'b1;
               cmd.pos      = hit_pos;
               occ_in       = occ_ff - 1'b1;
               status_in    = ST_INVAL;
            end else begin
               status_in = ST_NOENTRY;
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   assign cell_ctl = fire ? cmd : '0;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (fire) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         cap_ff       <= CAP_BITS'(CAP_RESET);
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            occ_ff <= occ_in;
         end
         if (csr_ch.valid) begin
            cap_ff <= csr_ch.capacity;
         end
      end
      if (accept) begin
         func_ff <= req_ch.func;
         key_ff  <= req_ch.lookup_key;
         val_ff  <= req_ch.fill_value[PAYLOAD_BITS-1:0];
      end
      if (fire) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         evf_ff    <= evf_in;
         evk_ff    <= evk_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.read_value   = read_ff;
   assign rsp_ch.evicted_flag = evf_ff;
   assign rsp_ch.evicted_key  = evk_ff;

endmodule

// ----- design/lkc_checker.sv -----
// Port-level checks of the LRU keyed cache, bound to lru_keyed_cache.
// Depends on lkc_pkg and on the top level's channel ports.
module lkc_checker import lkc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_BITS-1:0] status,
   input logic [WORD_BITS-1:0]   read_value,
   input logic                   evicted_flag,
   input logic [KEY_BITS-1:0]    evicted_key
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(evicted_key))
      else $error("response changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_read_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_HIT |-> read_value == '0)
      else $error("read_value nonzero without a hit");

   a_evict_on_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && evicted_flag |-> status == ST_FILLED)
      else $error("eviction reported outside a fill");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !evicted_flag |-> evicted_key == '0)
      else $error("evicted_key nonzero without eviction");

endmodule

bind lru_keyed_cache lkc_checker u_lkc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .status       (rsp_ch.status),
   .read_value   (rsp_ch.read_value),
   .evicted_flag (rsp_ch.evicted_flag),
   .evicted_key  (rsp_ch.evicted_key)
);

// ----- bench/lru_cache_monitor.sv -----
// Passive monitor for the LRU keyed cache: tracks the cache contents and recency order,
// predicts each response and compares it with what the block returns.
// Depends on lkc_pkg and the channel interfaces in lkc_channels.
module lru_cache_monitor import lkc_pkg::*; (
   input  logic clock,
   input  logic reset,
   lkc_req_if   req_ch,
   lkc_rsp_if   rsp_ch,
   lkc_csr_if   csr_ch,
   output int   fail_count,
   output int   pending,
   output int   rsp_total,
   output int   hit_total,
   output int   evict_total
);

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   read_value;
      logic                   evicted_flag;
      logic [KEY_BITS-1:0]    evicted_key;
   } cache_rsp_type;

   localparam logic [WORD_BITS-1:0] PAYLOAD_MASK =
      {WORD_BITS{1'b1}} >> (WORD_BITS - LKC_PAYLOAD_BITS);

   // shadow copy of the cache; age 0 is the most recent entry
   logic [KEY_BITS-1:0]  tag_mem  [LKC_ENTRIES];
   logic [WORD_BITS-1:0] data_mem [LKC_ENTRIES];
   bit                   live     [LKC_ENTRIES];
   int                   age      [LKC_ENTRIES];
   int                   fill_count;
   logic [CAP_BITS-1:0]  cap_reg;

   cache_rsp_type rsp_expected [$];
   cache_rsp_type want;
   cache_rsp_type got;
   int            errors;
   int            seen;
   int            hits;
   int            evicts;

   function automatic int find_key(input logic [KEY_BITS-1:0] k);
      for (int i = 0; i < LKC_ENTRIES; i++)
         if (live[i] && tag_mem[i] == k) return i;
      return -1;
   endfunction

   function automatic int cap_limit();
      int c;
      c = int'(cap_reg);
      if (c == 0) c = 1;
      if (c > LKC_ENTRIES) c = LKC_ENTRIES;
      return c;
   endfunction

   task automatic make_newest(input int s);
      int r;
      r = age[s];
      for (int i = 0; i < LKC_ENTRIES; i++)
         if (live[i] && age[i] < r) age[i]++;
      age[s] = 0;
   endtask

   task automatic remove_slot(input int s);
      int r;
      r = age[s];
      live[s] = 1'b0;
      age[s] = 0;
      for (int i = 0; i < LKC_ENTRIES; i++)
         if (live[i] && age[i] > r) age[i]--;
      if (fill_count > 0) fill_count--;
   endtask

   task automatic predict_outcome(input logic [FUNC_BITS-1:0] f,
                                  input logic [KEY_BITS-1:0] k,
                                  input logic [WORD_BITS-1:0] v,
                                  output cache_rsp_type r);
      int s;
      int lru;
      r = '0;
      r.status = ST_MISS;
      s = find_key(k);
      case (f)
         FUNC_LOOKUP: begin
            if (s >= 0) begin
               make_newest(s);
               r.status = ST_HIT;
               r.read_value = data_mem[s];
            end
         end
         FUNC_FILL: begin
            r.status = ST_FILLED;
            if (s >= 0) begin
               data_mem[s] = v & PAYLOAD_MASK;
               make_newest(s);
            end else begin
               if (fill_count >= cap_limit()) begin
                  lru = -1;
                  for (int i = 0; i < LKC_ENTRIES; i++)
                     if (live[i] && (lru < 0 || age[i] > age[lru])) lru = i;
                  if (lru >= 0) begin
                     r.evicted_flag = 1'b1;
                     r.evicted_key = tag_mem[lru];
                     remove_slot(lru);
                  end
               end
               for (int i = 0; i < LKC_ENTRIES && s < 0; i++)
                  if (!live[i]) s = i;
               if (s >= 0) begin
                  for (int i = 0; i < LKC_ENTRIES; i++)
                     if (live[i]) age[i]++;
                  live[s] = 1'b1;
                  tag_mem[s] = k;
                  data_mem[s] = v & PAYLOAD_MASK;
                  age[s] = 0;
                  fill_count++;
               end
            end
         end
         FUNC_INVAL: begin
            if (s >= 0) begin
               remove_slot(s);
               r.status = ST_INVAL;
            end else begin
               r.status = ST_NOENTRY;
            end
         end
         default: ;  // unused code: nothing changes, reported as a miss
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LKC_ENTRIES; i++) begin
            live[i] = 1'b0;
            age[i] = 0;
         end
         fill_count = 0;
         cap_reg = CAP_BITS'(CAP_RESET);
         rsp_expected.delete();
         errors = 0;
         seen = 0;
         hits = 0;
         evicts = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) cap_reg = csr_ch.capacity;
         // retire the response first: it belongs to an older request
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.read_value = rsp_ch.read_value;
            got.evicted_flag = rsp_ch.evicted_flag;
            got.evicted_key = rsp_ch.evicted_key;
            if (rsp_expected.size() == 0) begin
               if (errors < 10)
                  $display("unexpected response: status %0d read %h evict %b key %h",
                           got.status, got.read_value, got.evicted_flag, got.evicted_key);
               errors++;
            end else begin
               want = rsp_expected.pop_front();
               if (got.status !== want.status || got.read_value !== want.read_value ||
                   got.evicted_flag !== want.evicted_flag ||
                   got.evicted_key !== want.evicted_key) begin
                  if (errors < 10) begin
                     $display("response %0d mismatch (expected / actual):", seen);
                     $display("  status %0d / %0d  read %h / %h", want.status, got.status,
                              want.read_value, got.read_value);
                     $display("  evicted %b / %b  key %h / %h", want.evicted_flag,
                              got.evicted_flag, want.evicted_key, got.evicted_key);
                  end
                  errors++;
               end
            end
            seen++;
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_outcome(req_ch.func, req_ch.lookup_key, req_ch.fill_value, want);
            if (want.status == ST_HIT) hits++;
            if (want.evicted_flag) evicts++;
            rsp_expected.push_back(want);
         end
      end
      fail_count  <= errors;
      pending     <= rsp_expected.size();
      rsp_total   <= seen;
      hit_total   <= hits;
      evict_total <= evicts;
   end

endmodule

// ----- bench/lru_keyed_cache_test.sv -----
// Top of the LRU keyed cache bench: clock, reset, request and capacity stimulus,
// response back-pressure and the verdict. Depends on lkc_pkg, lkc_channels,
// the lru_keyed_cache design and lru_cache_monitor.
module lru_keyed_cache_test import lkc_pkg::*; ;

   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASES     = 10;
   localparam int PHASE_REQS = 190;

   logic clock;
   logic reset;

   lkc_req_if req_ch();
   lkc_rsp_if rsp_ch();
   lkc_csr_if csr_ch();

   int fail_count;
   int pending;
   int rsp_total;
   int hit_total;
   int evict_total;

   bit                   no_idle;
   bit                   rsp_hold_req;
   int                   cap_writes;
   logic [KEY_BITS-1:0]  key_pool [24];
   logic [CAP_BITS-1:0]  cap_plan [PHASES];

   lru_keyed_cache dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   lru_cache_monitor lru_watch (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .fail_count  (fail_count),
      .pending     (pending),
      .rsp_total   (rsp_total),
      .hit_total   (hit_total),
      .evict_total (evict_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // request sender; valid stays high when the next request follows at once
   task automatic send_req(input logic [FUNC_BITS-1:0] f, input logic [KEY_BITS-1:0] k,
                           input logic [WORD_BITS-1:0] v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= f;
      req_ch.lookup_key <= k;
      req_ch.fill_value <= v;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop sending and wait until every outstanding response is back
   task automatic drain_rsps();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_BITS-1:0] c);
      csr_ch.valid    <= 1'b1;
      csr_ch.capacity <= c;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      cap_writes++;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            stall = 150;
            rsp_hold_req = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stim
      int                   counted;
      int                   span;
      int                   roll;
      int                   pick;
      logic [FUNC_BITS-1:0] op;
      logic [KEY_BITS-1:0]  key;
      logic [WORD_BITS-1:0] value;
      logic [KEY_BITS-1:0]  ones;

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_LOOKUP;
      req_ch.lookup_key <= '0;
      req_ch.fill_value <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.capacity   <= '0;
      no_idle      = 1'b0;
      rsp_hold_req = 1'b0;
      cap_writes   = 0;
      ones = {KEY_BITS{1'b1}};
      for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = ones;
      cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd3, 5'd17, 5'd12, 5'd2, 5'd16};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cache, extreme keys and payloads, refresh, unused code
      send_req(FUNC_LOOKUP, '0, '0);
      send_req(FUNC_INVAL, '0, ones);
      send_req(FUNC_FILL, '0, ones);
      send_req(FUNC_FILL, ones, '0);
      send_req(FUNC_LOOKUP, '0, '0);
      send_req(FUNC_LOOKUP, ones, ones);
      send_req(FUNC_FILL, '0, 64'h5555_5555_5555_5555);
      send_req(FUNC_UNUSED, ones, ones);
      send_req(FUNC_INVAL, ones, '0);
      send_req(FUNC_LOOKUP, ones, '0);
      drain_rsps();

      // directed: two entries, lookup reorders which one gets evicted
      set_capacity(5'd2);
      send_req(FUNC_FILL, key_pool[2], {$urandom, $urandom});
      send_req(FUNC_LOOKUP, '0, '0);
      send_req(FUNC_FILL, key_pool[3], {$urandom, $urandom});
      send_req(FUNC_LOOKUP, key_pool[2], '0);
      send_req(FUNC_FILL, '0, ones);
      send_req(FUNC_FILL, key_pool[2], 64'hAAAA_AAAA_AAAA_AAAA);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_rsps();
         set_capacity(cap_plan[phase]);
         counted = 0;
         span = 8;
         while (counted < PHASE_REQS) begin
            if (counted % 40 == 0) begin
               no_idle = ($urandom_range(0, 3) == 0);
               span = $urandom_range(2, 24);
            end
            // long response hold-off with the sender pushing back-to-back
            if (phase == 2 && counted == 80) begin
               rsp_hold_req = 1'b1;
               no_idle = 1'b1;
            end
            if (phase == 6 && counted == 100) drain_rsps();

            roll = $urandom_range(0, 99);
            if (roll < 45)      op = FUNC_LOOKUP;
            else if (roll < 80) op = FUNC_FILL;
            else if (roll < 95) op = FUNC_INVAL;
            else                op = FUNC_UNUSED;
            pick = $urandom_range(0, 99);
            key = (pick < 90) ? key_pool[$urandom_range(0, span - 1)] : {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (pick == 0)      value = '0;
            else if (pick == 1) value = ones;
            else                value = {$urandom, $urandom};
            send_req(op, key, value);
            if (op != FUNC_UNUSED) counted++;
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      for (int w = 0; w < 5000 && pending != 0; w++) @(posedge clock);
      repeat (10) @(posedge clock);

      if (pending != 0) $display("%0d responses never arrived", pending);
      $display("covered %0d responses under %0d capacity writes (0, 1, 16, 31 among them)",
               rsp_total, cap_writes);
      $display("  %0d lookup hits and %0d evictions seen", hit_total, evict_total);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
